// File: rtl/tocalc_pkg.sv
// ----------------------------------------------------------------------------
// tocalc_pkg
// Shared types, character codes and helpers for the text calculator core.
// ----------------------------------------------------------------------------
`default_nettype none

package tocalc_pkg;

   localparam int CHAR_WIDTH    = 8;
   localparam int OPERAND_WIDTH = 31;
   localparam int VALUE_WIDTH   = 32;
   localparam int STATUS_WIDTH  = 2;
   localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);

   localparam logic [OPERAND_WIDTH-1:0] OPERAND_MAX = {OPERAND_WIDTH{1'b1}};

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] OP_PLUS    = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] OP_MINUS   = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] OP_STAR    = 8'h2A;
   localparam logic [CHAR_WIDTH-1:0] OP_SLASH   = 8'h2F;
   localparam logic [CHAR_WIDTH-1:0] OP_PERCENT = 8'h25;
   localparam logic [CHAR_WIDTH-1:0] OP_CARET   = 8'h5E;

   localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_BAD_OP   = 2'd2;

   typedef struct packed {
      logic                     start;
      logic [CHAR_WIDTH-1:0]    op;
      logic [OPERAND_WIDTH-1:0] x;
      logic [OPERAND_WIDTH-1:0] y;
   } alu_cmd_type;

   typedef struct packed {
      logic                    done;
      logic [VALUE_WIDTH-1:0]  value;
      logic [STATUS_WIDTH-1:0] status;
   } alu_res_type;

   function automatic logic is_digit(input logic [CHAR_WIDTH-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // acc * 10 + digit, held at OPERAND_MAX once reached
   function automatic logic [OPERAND_WIDTH-1:0] accumulate(
      input logic [OPERAND_WIDTH-1:0] acc,
      input logic [CHAR_WIDTH-1:0]    c
   );
      logic [OPERAND_WIDTH+3:0] n;
      logic [CHAR_WIDTH-1:0]    d;
      d = c - CHAR_ZERO;
      n = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{(OPERAND_WIDTH-4){1'b0}}, d[3:0]};
      if (n >= {4'b0000, OPERAND_MAX}) begin
         return OPERAND_MAX;
      end
      return n[OPERAND_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/tocalc_if.sv
// ----------------------------------------------------------------------------
// tocalc channel interfaces
// Valid/ready channels for the character stream and the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

interface tocalc_req_if;
   logic                              valid;
   logic                              ready;
   logic [tocalc_pkg::CHAR_WIDTH-1:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface tocalc_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [tocalc_pkg::VALUE_WIDTH-1:0]  value;
   logic        [tocalc_pkg::STATUS_WIDTH-1:0] status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/tocalc_alu.sv
// ----------------------------------------------------------------------------
// tocalc_alu
// Sequenced arithmetic unit: add, subtract, multiply, restoring divide and
// power by squaring; multiply and power share one 32-bit multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module tocalc_alu (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tocalc_pkg::alu_cmd_type cmd,
   output      tocalc_pkg::alu_res_type res
);
   import tocalc_pkg::*;

   typedef enum logic [5:0] {
      U_IDLE    = 6'b000001,
      U_MUL     = 6'b000010,
      U_DIV     = 6'b000100,
      U_POW_MUL = 6'b001000,
      U_POW_SQ  = 6'b010000,
      U_DONE    = 6'b100000
   } alu_state_type;

   alu_state_type             state_ff, state_in;
   logic [VALUE_WIDTH-1:0]    acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0]    base_ff, base_in;
   logic [OPERAND_WIDTH-1:0]  exp_ff, exp_in;
   logic [CNT_WIDTH-1:0]      cnt_ff, cnt_in;
   logic [CHAR_WIDTH-1:0]     op_ff, op_in;
   logic [VALUE_WIDTH-1:0]    value_ff, value_in;
   logic [STATUS_WIDTH-1:0]   status_ff, status_in;

   logic [VALUE_WIDTH-1:0]    mul_a;
   logic [VALUE_WIDTH-1:0]    prod;
   logic [VALUE_WIDTH-1:0]    rem_shift;
   logic [VALUE_WIDTH:0]      diff;
   logic                      fits;
   logic [VALUE_WIDTH-1:0]    rem_next;
   logic [OPERAND_WIDTH-1:0]  quo_next;

   assign mul_a     = (state_ff == U_POW_SQ) ? base_ff : acc_ff;
   assign prod      = mul_a * base_ff;
   assign rem_shift = {acc_ff[VALUE_WIDTH-2:0], base_ff[OPERAND_WIDTH-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, exp_ff};
   assign fits      = !diff[VALUE_WIDTH];
   assign rem_next  = fits ? diff[VALUE_WIDTH-1:0] : rem_shift;
   assign quo_next  = {base_ff[OPERAND_WIDTH-2:0], fits};

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      exp_in    = exp_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      value_in  = value_ff;
      status_in = status_ff;
      case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               op_in     = cmd.op;
               status_in = ST_OK;
               value_in  = '0;
               acc_in    = {1'b0, cmd.x};
               base_in   = {1'b0, cmd.y};
               exp_in    = cmd.y;
               state_in  = U_DONE;
               case (cmd.op)
                  OP_PLUS:  value_in = {1'b0, cmd.x} + {1'b0, cmd.y};
                  OP_MINUS: value_in = {1'b0, cmd.x} - {1'b0, cmd.y};
                  OP_STAR:  state_in = U_MUL;
                  OP_SLASH, OP_PERCENT: begin
                     if (cmd.y == '0) begin
                        status_in = ST_DIV_ZERO;
                     end else begin
                        acc_in   = '0;
                        base_in  = {1'b0, cmd.x};
                        cnt_in   = CNT_WIDTH'(OPERAND_WIDTH - 1);
                        state_in = U_DIV;
                     end
                  end
                  OP_CARET: begin
                     acc_in  = VALUE_WIDTH'(1);
                     base_in = {1'b0, cmd.x};
                     if (cmd.y == '0) begin
                        value_in = VALUE_WIDTH'(1);
                     end else begin
                        state_in = U_POW_MUL;
                     end
                  end
                  default: status_in = ST_BAD_OP;
               endcase
            end
         end
         U_MUL: begin
            value_in = prod;
            state_in = U_DONE;
         end
         U_DIV: begin
            acc_in  = rem_next;
            base_in = {1'b0, quo_next};
            cnt_in  = cnt_ff - CNT_WIDTH'(1);
            if (cnt_ff == '0) begin
               value_in = (op_ff == OP_SLASH) ? {1'b0, quo_next} : rem_next;
               state_in = U_DONE;
            end
         end
         U_POW_MUL: begin
            if (exp_ff[0]) begin
               acc_in = prod;
            end
            state_in = U_POW_SQ;
         end
         U_POW_SQ: begin
            base_in = prod;
            exp_in  = exp_ff >> 1;
            if (exp_ff[OPERAND_WIDTH-1:1] == '0) begin
               value_in = acc_ff;
               state_in = U_DONE;
            end else begin
               state_in = U_POW_MUL;
            end
         end
         U_DONE: state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      exp_ff    <= exp_in;
      cnt_ff    <= cnt_in;
      op_ff     <= op_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign res.done   = (state_ff == U_DONE);
   assign res.value  = value_ff;
   assign res.status = status_ff;

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == U_IDLE)
      else $error("start outside idle");

   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      state_ff == U_DIV |-> exp_ff != '0)
      else $error("divide step with zero divisor");

   a_zero_status : assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_DONE && status_ff == ST_DIV_ZERO)
         |-> (op_ff == OP_SLASH || op_ff == OP_PERCENT))
      else $error("divide-by-zero status for other operator");

endmodule

`default_nettype wire

// File: rtl/two_operand_text_calculator_core.sv
// ----------------------------------------------------------------------------
// two_operand_text_calculator_core
// Character-driven two-operand calculator with one result per expression.
// ----------------------------------------------------------------------------
// A character transfer is accepted whenever an operand or the operator is
// being read. The terminator starts the shared arithmetic unit and the input
// stalls until the result sits in the output register. Add, subtract, unknown
// operators and a zero divisor go straight from idle to done, multiply passes
// through the multiply state, divide and modulo take one quotient bit per
// cycle over 31 bits, and power does one conditional multiply and one
// squaring on the one multiplier for each exponent bit. A result still
// held in the output register adds its stall.
`default_nettype none

module two_operand_text_calculator_core (
   input wire logic   clock,
   input wire logic   reset,
   tocalc_req_if.sink   req,
   tocalc_rsp_if.source rsp
);
   import tocalc_pkg::*;

   typedef enum logic [3:0] {
      S_LEFT  = 4'b0001,
      S_RIGHT = 4'b0010,
      S_EXEC  = 4'b0100,
      S_EMIT  = 4'b1000
   } core_state_type;

   core_state_type            state_ff, state_in;
   logic [OPERAND_WIDTH-1:0]  left_ff, left_in;
   logic [OPERAND_WIDTH-1:0]  right_ff, right_in;
   logic [CHAR_WIDTH-1:0]     op_ff, op_in;
   logic                      out_valid_ff, out_valid_in;
   logic [VALUE_WIDTH-1:0]    out_value_ff, out_value_in;
   logic [STATUS_WIDTH-1:0]   out_status_ff, out_status_in;

   alu_cmd_type               alu_cmd;
   alu_res_type               alu_res;
   logic                      alu_start;
   logic                      in_xfer;
   logic                      digit;

   assign req.ready = (state_ff == S_LEFT) || (state_ff == S_RIGHT);
   assign in_xfer   = req.valid && req.ready;
   assign digit     = is_digit(req.char_in);

   assign alu_cmd = '{start: alu_start, op: op_ff, x: left_ff, y: right_ff};

   always_comb begin
      state_in      = state_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      op_in         = op_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      alu_start     = 1'b0;
      case (state_ff)
         S_LEFT: begin
            if (in_xfer) begin
               if (digit) begin
                  left_in = accumulate(left_ff, req.char_in);
               end else if (req.char_in != CHAR_NUL) begin
                  op_in    = req.char_in;
                  state_in = S_RIGHT;
               end else begin
                  alu_start = 1'b1;
                  state_in  = S_EXEC;
               end
            end
         end
         S_RIGHT: begin
            if (in_xfer) begin
               if (digit) begin
                  right_in = accumulate(right_ff, req.char_in);
               end else begin
                  alu_start = 1'b1;
                  state_in  = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (alu_res.done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in  = 1'b1;
               out_value_in  = alu_res.value;
               out_status_in = alu_res.status;
               state_in      = S_LEFT;
            end
         end
         default: state_in = S_LEFT;
      endcase
      if (alu_start) begin
         left_in  = '0;
         right_in = '0;
         op_in    = CHAR_NUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LEFT;
         left_ff      <= '0;
         right_ff     <= '0;
         op_ff        <= CHAR_NUL;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         op_ff        <= op_in;
         out_valid_ff <= out_valid_in;
      end
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
   end

   tocalc_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .res   (alu_res)
   );

   assign rsp.valid  = out_valid_ff;
   assign rsp.value  = out_value_ff;
   assign rsp.status = out_status_ff;

   a_done_to_emit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && alu_res.done) |=> state_ff == S_EMIT)
      else $error("unit result not taken to emit");

   a_rise_from_emit : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside emit");

   a_start_clears : assert property (@(posedge clock) disable iff (reset)
      alu_start |=> (left_ff == '0 && right_ff == '0 && op_ff == CHAR_NUL))
      else $error("operands not cleared after expression end");

endmodule

`default_nettype wire
